[hw/rtl/page_table_occupancy_counter_top_macros.svh]
// Assertion macros for the page table occupancy counter.
// Expects signals clk and rst_n in the including module's scope.
`ifndef PAGE_TABLE_OCCUPANCY_COUNTER_TOP_MACROS_SVH
`define PAGE_TABLE_OCCUPANCY_COUNTER_TOP_MACROS_SVH

// same-cycle implication
`define PTOC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptoc assertion failed");

// next-cycle implication
`define PTOC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptoc assertion failed");

`endif

[hw/rtl/ptoc_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, constants and the command type of the occupancy counter.
// No dependencies.
package ptoc_pkg;

    localparam int PAGE_W      = 20;
    localparam int COUNT_W     = 16;
    localparam int TBL_IDX_W   = 10;
    localparam int TBL_CNT_W   = 11;
    localparam int PIECE_W     = 6;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_AW     = 1;

    localparam logic [TBL_CNT_W-1:0] PAGES_PER_TABLE = 11'd1024;
    localparam logic [COUNT_W-1:0]   MAX_RUN_PAGES   = 16'd32768;
    localparam logic [COUNT_W-1:0]   THRESH_RESET    = 16'd8;

    typedef struct packed {
        logic                dealloc;
        logic [PAGE_W-1:0]   page;
        logic [COUNT_W-1:0]  remaining;
        logic                map_req;
        logic [PIECE_W-1:0]  total;
    } cmd_t;

endpackage

[hw/rtl/ptoc_if.sv]
`timescale 1ns / 1ps
// Channel interfaces: input transactions, result transactions, config writes.
// Depends on ptoc_pkg.
interface ptoc_in_if;
    logic                               valid;
    logic                               ready;
    logic                               action;
    logic [ptoc_pkg::PAGE_W-1:0]        page_number;
    logic [ptoc_pkg::COUNT_W-1:0]       page_count;

    modport source (output valid, action, page_number, page_count, input ready);
    modport sink (input valid, action, page_number, page_count, output ready);
endinterface

interface ptoc_out_if;
    logic                               valid;
    logic                               ready;
    logic [ptoc_pkg::TBL_IDX_W-1:0]     table_index;
    logic [ptoc_pkg::TBL_CNT_W-1:0]     table_count;
    logic                               unmap_table;
    logic                               map_request;
    logic                               count_error;
    logic                               last;

    modport source (output valid, table_index, table_count, unmap_table, map_request,
                    count_error, last, input ready);
    modport sink (input valid, table_index, table_count, unmap_table, map_request,
                  count_error, last, output ready);
endinterface

interface ptoc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ptoc_pkg::COUNT_W-1:0]       data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[hw/rtl/ptoc_front.sv]
`timescale 1ns / 1ps
// Front end: accepts input transactions, clamps the run, counts pieces, flags map.
// Depends on ptoc_pkg and ptoc_if.
module ptoc_front (
    input  logic                clk,
    input  logic                rst_n,
    ptoc_in_if.sink             in_item,
    ptoc_cfg_if.sink            cfg,
    input  logic                clear_done,
    input  logic                q_full,
    output logic                q_push,
    output ptoc_pkg::cmd_t      q_cmd
);

    logic [ptoc_pkg::COUNT_W-1:0] thresh_reg;
    logic [ptoc_pkg::COUNT_W-1:0] thresh_next;
    logic                         cmd_valid_reg;
    logic                         cmd_valid_next;
    ptoc_pkg::cmd_t               cmd_reg;
    ptoc_pkg::cmd_t               cmd_next;
    logic [ptoc_pkg::COUNT_W-1:0] clamped;
    logic [ptoc_pkg::COUNT_W-1:0] span;
    logic                         accept;

    assign cfg.ready     = 1'b1;
    assign q_push        = cmd_valid_reg && !q_full;
    assign q_cmd         = cmd_reg;
    assign in_item.ready = clear_done && (!cmd_valid_reg || !q_full);
    assign accept        = in_item.valid && in_item.ready;

    always_comb
    begin
        clamped = (in_item.page_count > ptoc_pkg::MAX_RUN_PAGES) ?
                  ptoc_pkg::MAX_RUN_PAGES : in_item.page_count;
        // last page offset from the start of the first table
        span = {6'd0, in_item.page_number[ptoc_pkg::TBL_IDX_W-1:0]} + clamped - 16'd1;

        cmd_next.dealloc   = in_item.action;
        cmd_next.page      = in_item.page_number;
        cmd_next.remaining = clamped;
        cmd_next.map_req   = !in_item.action && (clamped > thresh_reg);
        cmd_next.total     = span[ptoc_pkg::COUNT_W-1:ptoc_pkg::TBL_IDX_W] + 6'd1;

        cmd_valid_next = cmd_valid_reg && !q_push;
        if (accept && (clamped != '0))
        begin
            cmd_valid_next = 1'b1;
        end

        thresh_next = thresh_reg;
        if (cfg.valid && cfg.ready)
        begin
            thresh_next = cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg    <= ptoc_pkg::THRESH_RESET;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            thresh_reg    <= thresh_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

[hw/rtl/ptoc_fifo.sv]
`timescale 1ns / 1ps
// Short command queue between front and back end.
// Depends on ptoc_pkg.
module ptoc_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ptoc_pkg::cmd_t      push_cmd,
    output logic                full,
    input  logic                pop,
    output ptoc_pkg::cmd_t      pop_cmd,
    output logic                empty
);

    ptoc_pkg::cmd_t               entry_reg [ptoc_pkg::FIFO_DEPTH];
    logic [ptoc_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [ptoc_pkg::FIFO_AW-1:0] wr_ptr_next;
    logic [ptoc_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [ptoc_pkg::FIFO_AW-1:0] rd_ptr_next;
    logic [ptoc_pkg::FIFO_AW:0]   count_reg;
    logic [ptoc_pkg::FIFO_AW:0]   count_next;
    logic                         do_push;
    logic                         do_pop;

    assign full    = count_reg == (ptoc_pkg::FIFO_AW+1)'(ptoc_pkg::FIFO_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[hw/rtl/ptoc_back.sv]
`timescale 1ns / 1ps
// Back end: clears the counter memory, walks each run table by table, updates counters.
// Depends on ptoc_pkg, ptoc_if and the assertion macro header.
`include "page_table_occupancy_counter_top_macros.svh"
module ptoc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  ptoc_pkg::cmd_t      q_cmd,
    output logic                q_pop,
    output logic                clear_done,
    ptoc_out_if.source          out_result
);

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_UPDATE} state_t;

    state_t                         state_reg;
    logic [ptoc_pkg::TBL_IDX_W-1:0] clr_reg;
    logic [ptoc_pkg::PAGE_W-1:0]    page_reg;
    logic [ptoc_pkg::COUNT_W-1:0]   rem_reg;
    logic [ptoc_pkg::PIECE_W-1:0]   k_reg;
    logic [ptoc_pkg::PIECE_W-1:0]   total_reg;
    logic                           dealloc_reg;
    logic                           map_reg;
    logic                           out_valid_reg;
    logic [ptoc_pkg::TBL_IDX_W-1:0] out_index_reg;
    logic [ptoc_pkg::TBL_CNT_W-1:0] out_count_reg;
    logic                           out_unmap_reg;
    logic                           out_map_reg;
    logic                           out_err_reg;
    logic                           out_last_reg;

    logic [ptoc_pkg::TBL_CNT_W-1:0] mem [2**ptoc_pkg::TBL_IDX_W];
    logic [ptoc_pkg::TBL_CNT_W-1:0] rdata_reg;
    logic                           mem_we;
    logic [ptoc_pkg::TBL_IDX_W-1:0] mem_waddr;
    logic [ptoc_pkg::TBL_CNT_W-1:0] mem_wdata;

    logic [ptoc_pkg::TBL_CNT_W-1:0] room;
    logic [ptoc_pkg::TBL_CNT_W-1:0] take;
    logic [ptoc_pkg::TBL_CNT_W:0]   sum;
    logic [ptoc_pkg::TBL_CNT_W-1:0] new_cnt;
    logic                           new_err;
    logic                           new_unmap;
    logic                           is_last;
    logic                           is_mid;
    logic                           can_load;
    logic                           adv;

    assign clear_done = state_reg != ST_CLEAR;
    assign q_pop      = (state_reg == ST_IDLE) && !q_empty;
    assign can_load   = !out_valid_reg || out_result.ready;
    assign adv        = (state_reg == ST_UPDATE) && can_load;

    assign out_result.valid       = out_valid_reg;
    assign out_result.table_index = out_index_reg;
    assign out_result.table_count = out_count_reg;
    assign out_result.unmap_table = out_unmap_reg;
    assign out_result.map_request = out_map_reg;
    assign out_result.count_error = out_err_reg;
    assign out_result.last        = out_last_reg;

    always_comb
    begin
        room    = ptoc_pkg::PAGES_PER_TABLE - {1'b0, page_reg[ptoc_pkg::TBL_IDX_W-1:0]};
        take    = (rem_reg < {5'd0, room}) ? rem_reg[ptoc_pkg::TBL_CNT_W-1:0] : room;
        is_last = (k_reg + 6'd1) == total_reg;
        is_mid  = !dealloc_reg && (k_reg != '0) && !is_last;
        sum     = {1'b0, rdata_reg} + {1'b0, take};

        new_cnt   = rdata_reg;
        new_err   = 1'b0;
        new_unmap = 1'b0;
        if (dealloc_reg)
        begin
            if (take > rdata_reg)
            begin
                new_cnt = '0;
                new_err = 1'b1;
            end
            else
            begin
                new_cnt = rdata_reg - take;
            end
            new_unmap = new_cnt == '0;
        end
        else if (is_mid)
        begin
            new_cnt = ptoc_pkg::PAGES_PER_TABLE;
        end
        else if (sum > {1'b0, ptoc_pkg::PAGES_PER_TABLE})
        begin
            new_cnt = ptoc_pkg::PAGES_PER_TABLE;
            new_err = 1'b1;
        end
        else
        begin
            new_cnt = sum[ptoc_pkg::TBL_CNT_W-1:0];
        end

        mem_we    = (state_reg == ST_CLEAR) || adv;
        mem_waddr = (state_reg == ST_CLEAR) ? clr_reg :
                    page_reg[ptoc_pkg::PAGE_W-1:ptoc_pkg::PAGE_W-ptoc_pkg::TBL_IDX_W];
        mem_wdata = (state_reg == ST_CLEAR) ? '0 : new_cnt;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[page_reg[ptoc_pkg::PAGE_W-1:ptoc_pkg::PAGE_W-ptoc_pkg::TBL_IDX_W]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_result.ready && !adv)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == '1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        page_reg    <= q_cmd.page;
                        rem_reg     <= q_cmd.remaining;
                        total_reg   <= q_cmd.total;
                        dealloc_reg <= q_cmd.dealloc;
                        map_reg     <= q_cmd.map_req;
                        k_reg       <= '0;
                        state_reg   <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    if (can_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_index_reg <=
                            page_reg[ptoc_pkg::PAGE_W-1:ptoc_pkg::PAGE_W-ptoc_pkg::TBL_IDX_W];
                        out_count_reg <= new_cnt;
                        out_unmap_reg <= new_unmap;
                        out_map_reg   <= map_reg && (k_reg == '0);
                        out_err_reg   <= new_err;
                        out_last_reg  <= is_last;
                        rem_reg       <= rem_reg - {5'd0, take};
                        page_reg      <= page_reg + {9'd0, take};
                        k_reg         <= k_reg + 6'd1;
                        state_reg     <= is_last ? ST_IDLE : ST_READ;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `PTOC_ASSERT_NOW(a_last_drains, adv && is_last, rem_reg == {5'd0, take})
    `PTOC_ASSERT_NOW(a_unmap_zero, out_valid_reg && out_unmap_reg, out_count_reg == '0)
    `PTOC_ASSERT_NOW(a_count_range, out_valid_reg,
                     out_count_reg <= ptoc_pkg::PAGES_PER_TABLE)
    `PTOC_ASSERT_NOW(a_map_alloc, out_valid_reg && out_map_reg, !out_unmap_reg)
    `PTOC_ASSERT_NEXT(a_piece_step, adv && !is_last,
                      state_reg == ST_READ && k_reg == $past(k_reg) + 6'd1)

endmodule

[hw/rtl/page_table_occupancy_counter_top.sv]
// A result passes through the front end's command register, the command queue, the back
// end's idle, read and update states and its output register; each further table of the
// same run takes another memory read, then an update. The back end walks the counter
// memory for one transaction at a time; the queue lets the front end accept more meanwhile.
// Reset: a clearing pass over all 1024 counters zeroes them; input is not ready
// until it ends, config writes are taken throughout. Threshold resets to 8.
`timescale 1ns / 1ps
// Top level: front end, command queue and back end. Depends on ptoc_pkg, ptoc_if, ptoc_front, ptoc_fifo, ptoc_back.
module page_table_occupancy_counter_top (
    input  logic        clk,
    input  logic        rst_n,
    ptoc_in_if.sink     in_item,
    ptoc_cfg_if.sink    cfg,
    ptoc_out_if.source  out_result
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    logic           clear_done;
    ptoc_pkg::cmd_t push_cmd;
    ptoc_pkg::cmd_t pop_cmd;

    ptoc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_item    (in_item),
        .cfg        (cfg),
        .clear_done (clear_done),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    ptoc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    ptoc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_cmd      (pop_cmd),
        .q_pop      (q_pop),
        .clear_done (clear_done),
        .out_result (out_result)
    );

endmodule
